### rtl/fifo_queue_unique_keys_defines.svh
// assertion macros for the unique-key queue
// expects clk and rst in the scope of each use
`ifndef FIFO_QUEUE_UNIQUE_KEYS_DEFINES_SVH
`define FIFO_QUEUE_UNIQUE_KEYS_DEFINES_SVH

// consequent must hold in the same cycle
`define FQU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the next cycle
`define FQU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/fqu_pkg.sv
// types and codes shared by the unique-key queue
// no dependencies
package fqu_pkg;

  localparam int FQU_DEPTH = 16;

  localparam int KEY_W  = 32;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 5;

  localparam logic [1:0] REQ_ENQ = 2'd0;
  localparam logic [1:0] REQ_DEQ = 2'd1;
  localparam logic [1:0] REQ_QRY = 2'd2;
  localparam logic [1:0] REQ_DSP = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP   = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNDER = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd4;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [KEY_W-1:0] new_key;
    logic signed [KEY_W-1:0] new_data;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [CNT_W-1:0]        entry_count;
    logic                    is_empty;
    logic signed [KEY_W-1:0] entry_key;
    logic signed [KEY_W-1:0] entry_data;
    logic                    last;
  } rsp_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] data;
  } entry_t;

endpackage

### rtl/fqu_chan_if.sv
// valid/ready channel carrying one payload struct per item
// payload type comes from fqu_pkg at the point of instantiation
interface fqu_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/fqu_store.sv
// entry ring storage: one write port, one read port with registered data
// depends on fqu_pkg for entry_t
module fqu_store
  import fqu_pkg::*;
#(
  parameter int DEPTH = FQU_DEPTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  entry_t                   wr_entry,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output entry_t                   rd_entry
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule

### rtl/fifo_queue_unique_keys.sv
// Queue of key/data pairs in a ring of DEPTH entries with a duplicate-key check on
// enqueue. One request is taken at a time; req.ready is low while a request is being
// worked on or its result waits on rsp. Dequeue and query finish in the accept cycle.
// Enqueue into an empty queue also finishes at once; otherwise it walks the stored keys
// from oldest to newest through the single read port of the entry memory, one key a
// cycle once the first registered read returns, and stops early on a match. Display of
// a non-empty queue walks the same port and emits one entry per cycle while rsp keeps
// ready high; an empty queue answers display at once. The storage needs no clearing
// after reset.
`include "fifo_queue_unique_keys_defines.svh"

module fifo_queue_unique_keys
  import fqu_pkg::*;
#(
  parameter int DEPTH = FQU_DEPTH
) (
  input logic        clk,
  input logic        rst,
  fqu_chan_if.sink   req,
  fqu_chan_if.source rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DISP = 2'd2;

  logic [1:0]              state;
  logic [AW-1:0]           head;
  logic [AW-1:0]           tail;
  logic [CW-1:0]           count;
  logic [AW-1:0]           ptr;
  logic [CW-1:0]           issue_cnt;
  logic [CW-1:0]           chk_cnt;
  logic                    rd_vld;
  logic signed [KEY_W-1:0] key_reg;
  logic signed [KEY_W-1:0] data_reg;
  logic                    out_valid;
  rsp_t                    out_data;

  logic   accept;
  logic   walking;
  logic   consume;
  logic   issue;
  logic   last_chk;
  logic   full;
  logic   wr_en;
  entry_t wr_entry;
  entry_t rd_entry;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] s);
    ring_next = (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
  endfunction

  function automatic rsp_t mk_rsp(input logic [STAT_W-1:0] st, input logic [CW-1:0] cnt,
                                  input logic signed [KEY_W-1:0] k,
                                  input logic signed [KEY_W-1:0] d, input logic fin);
    rsp_t r;
    r.status      = st;
    r.entry_count = CNT_W'(cnt);
    r.is_empty    = (cnt == '0);
    r.entry_key   = k;
    r.entry_data  = d;
    r.last        = fin;
    mk_rsp = r;
  endfunction

  // no request is taken while reset is held
  assign req.ready = !rst && (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign accept   = req.valid && req.ready;
  assign walking  = (state == S_SCAN) || (state == S_DISP);
  assign consume  = rd_vld && ((state == S_SCAN) || !out_valid || rsp.ready);
  assign issue    = walking && (issue_cnt != count) && (!rd_vld || consume);
  assign last_chk = (chk_cnt + CW'(1)) == count;
  assign full     = (count == CW'(DEPTH));

  // write at the tail: from the request when empty, else after a clean scan if not full
  always_comb begin
    wr_en    = 1'b0;
    wr_entry = '{key: key_reg, data: data_reg};
    if (accept && req.data.req_type == REQ_ENQ && count == '0) begin
      wr_en    = 1'b1;
      wr_entry = '{key: req.data.new_key, data: req.data.new_data};
    end else if (state == S_SCAN && rd_vld && rd_entry.key != key_reg && last_chk && !full) begin
      wr_en = 1'b1;
    end
  end

  fqu_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (tail),
    .wr_entry (wr_entry),
    .rd_en    (issue),
    .rd_addr  (ptr),
    .rd_entry (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rsp.ready) begin
      out_valid <= 1'b0;
    end

    if (issue) begin
      ptr       <= ring_next(ptr);
      issue_cnt <= issue_cnt + CW'(1);
      rd_vld    <= 1'b1;
    end else if (consume) begin
      rd_vld <= 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.data.req_type)
            REQ_ENQ: begin
              if (count == '0) begin
                tail      <= ring_next(tail);
                count     <= CW'(1);
                out_valid <= 1'b1;
                out_data  <= mk_rsp(ST_OK, CW'(1), '0, '0, 1'b1);
              end else begin
                key_reg   <= req.data.new_key;
                data_reg  <= req.data.new_data;
                ptr       <= head;
                issue_cnt <= '0;
                chk_cnt   <= '0;
                state     <= S_SCAN;
              end
            end
            REQ_DEQ: begin
              out_valid <= 1'b1;
              if (count == '0) begin
                out_data <= mk_rsp(ST_UNDER, count, '0, '0, 1'b1);
              end else begin
                head     <= ring_next(head);
                count    <= count - CW'(1);
                out_data <= mk_rsp(ST_OK, count - CW'(1), '0, '0, 1'b1);
              end
            end
            REQ_QRY: begin
              out_valid <= 1'b1;
              out_data  <= mk_rsp(ST_OK, count, '0, '0, 1'b1);
            end
            REQ_DSP: begin
              if (count == '0) begin
                out_valid <= 1'b1;
                out_data  <= mk_rsp(ST_EMPTY, count, '0, '0, 1'b1);
              end else begin
                ptr       <= head;
                issue_cnt <= '0;
                chk_cnt   <= '0;
                state     <= S_DISP;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (rd_vld) begin
          chk_cnt <= chk_cnt + CW'(1);
          if (rd_entry.key == key_reg) begin
            out_valid <= 1'b1;
            out_data  <= mk_rsp(ST_DUP, count, '0, '0, 1'b1);
            rd_vld    <= 1'b0;
            state     <= S_IDLE;
          end else if (last_chk) begin
            out_valid <= 1'b1;
            rd_vld    <= 1'b0;
            state     <= S_IDLE;
            if (full) begin
              out_data <= mk_rsp(ST_FULL, count, '0, '0, 1'b1);
            end else begin
              tail     <= ring_next(tail);
              count    <= count + CW'(1);
              out_data <= mk_rsp(ST_OK, count + CW'(1), '0, '0, 1'b1);
            end
          end
        end
      end
      S_DISP: begin
        if (consume) begin
          chk_cnt   <= chk_cnt + CW'(1);
          out_valid <= 1'b1;
          out_data  <= mk_rsp(ST_OK, count, rd_entry.key, rd_entry.data, last_chk);
          if (last_chk) begin
            rd_vld <= 1'b0;
            state  <= S_IDLE;
          end
        end
      end
      default: begin
        state <= S_IDLE;
      end
    endcase

    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end
  end

  `FQU_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH), "fill count above depth")
  `FQU_ASSERT_NOW(a_ready_free, req.ready, !rsp.valid, "request taken while a result waits")
  `FQU_ASSERT_NOW(a_issue_bound, walking, issue_cnt <= count, "read walk past the fill")
  `FQU_ASSERT_NEXT(a_scan_done, state == S_SCAN && rd_vld && last_chk, rsp.valid && state == S_IDLE,
                   "scan ended without a result")

endmodule

### dv/fqu_queue_shadow_pkg.sv
`timescale 1ns / 1ps
// shadow copy of the unique-key queue: predicts result items and checks them
// depends on fqu_pkg for the request, result and entry types
package fqu_queue_shadow_pkg;
  import fqu_pkg::*;

  class fqu_queue_shadow;
    entry_t      held[$];
    rsp_t        owed[$];
    int unsigned bad_results;

    function void note_request(req_t q);
      logic [STAT_W-1:0] st;
      rsp_t              r;
      entry_t            e;
      bit                dup;
      st  = ST_OK;
      dup = 1'b0;
      case (q.req_type)
        REQ_ENQ: begin
          foreach (held[i]) if (held[i].key == q.new_key) dup = 1'b1;
          // duplicate check wins over the full check
          if (dup) st = ST_DUP;
          else if (held.size() >= FQU_DEPTH) st = ST_FULL;
          else begin
            e.key  = q.new_key;
            e.data = q.new_data;
            held.push_back(e);
          end
        end
        REQ_DEQ: begin
          if (held.size() == 0) st = ST_UNDER;
          else void'(held.pop_front());
        end
        REQ_DSP: begin
          if (held.size() == 0) st = ST_EMPTY;
          else begin
            // one item per stored entry, oldest first
            foreach (held[i]) begin
              r.status      = ST_OK;
              r.entry_count = CNT_W'(held.size());
              r.is_empty    = 1'b0;
              r.entry_key   = held[i].key;
              r.entry_data  = held[i].data;
              r.last        = (i == held.size() - 1);
              owed.push_back(r);
            end
            return;
          end
        end
        default: ;
      endcase
      r.status      = st;
      r.entry_count = CNT_W'(held.size());
      r.is_empty    = (held.size() == 0);
      r.entry_key   = '0;
      r.entry_data  = '0;
      r.last        = 1'b1;
      owed.push_back(r);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (owed.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result item: status %0d count %0d key %0d data %0d last %0b",
                   got.status, got.entry_count, got.entry_key, got.entry_data, got.last);
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status || got.entry_count !== want.entry_count ||
          got.is_empty !== want.is_empty || got.entry_key !== want.entry_key ||
          got.entry_data !== want.entry_data || got.last !== want.last) begin
        bad_results++;
        if (bad_results <= 10) begin
          $display("mismatch expected: status %0d count %0d empty %0b key %0d data %0d last %0b",
                   want.status, want.entry_count, want.is_empty, want.entry_key,
                   want.entry_data, want.last);
          $display("         actual:   status %0d count %0d empty %0b key %0d data %0d last %0b",
                   got.status, got.entry_count, got.is_empty, got.entry_key,
                   got.entry_data, got.last);
        end
      end
    endfunction
  endclass

endpackage

### dv/fifo_queue_unique_keys_test.sv
`timescale 1ns / 1ps
// testbench for fifo_queue_unique_keys: directed and random requests, checked by a shadow queue
// depends on fqu_pkg, fqu_chan_if, fqu_queue_shadow_pkg and the block itself
module fifo_queue_unique_keys_test;
  import fqu_pkg::*;
  import fqu_queue_shadow_pkg::*;

  logic clk = 1'b0;
  logic rst;
  bit   idle_on;

  fqu_chan_if #(.payload_t(req_t)) req_ch ();
  fqu_chan_if #(.payload_t(rsp_t)) rsp_ch ();

  fqu_queue_shadow shadow = new();

  fifo_queue_unique_keys dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // predict on accepted requests, then check accepted result items, in one place
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) shadow.note_request(req_ch.data);
      if (rsp_ch.valid && rsp_ch.ready) shadow.check_response(rsp_ch.data);
    end
  end

  always @(negedge clk) begin
    if (rst) rsp_ch.ready = 1'b0;
    else rsp_ch.ready = !(idle_on && $urandom_range(99) < 23);
  end

  // entered and left at a falling edge
  task automatic push_request(input logic [1:0] kind, input logic [31:0] key,
                              input logic [31:0] data);
    req_t r;
    int   gap;
    r.req_type = kind;
    r.new_key  = key;
    r.new_data = data;
    gap = 0;
    while (idle_on && $urandom_range(99) < 23) gap++;
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.data  = r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("** fifo_queue_unique_keys: FAILED **");
    $finish;
  end

  initial begin
    logic [1:0]  kind;
    logic [31:0] key;
    int          pick;
    bit          filling;
    rst          = 1'b1;
    idle_on      = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty queue corner cases
    push_request(REQ_DSP, 32'd0, 32'd0);
    push_request(REQ_DEQ, 32'd0, 32'd0);
    push_request(REQ_QRY, 32'd0, 32'd0);
    // extreme keys and data, and a duplicate
    push_request(REQ_ENQ, 32'h8000_0000, 32'h7fff_ffff);
    push_request(REQ_ENQ, 32'h8000_0000, 32'h1234_5678);
    push_request(REQ_ENQ, 32'h7fff_ffff, 32'h8000_0000);
    push_request(REQ_ENQ, 32'h0000_0000, 32'h0000_0000);
    push_request(REQ_ENQ, 32'hffff_ffff, 32'hffff_ffff);
    push_request(REQ_DSP, 32'd0, 32'd0);
    // fill to the top, then push past it
    for (int i = 0; i < FQU_DEPTH - 4; i++)
      push_request(REQ_ENQ, 32'd100 + i, $urandom);
    push_request(REQ_ENQ, 32'd555, 32'd1);
    push_request(REQ_ENQ, 32'h7fff_ffff, 32'd2);
    push_request(REQ_DSP, 32'd0, 32'd0);
    push_request(REQ_QRY, 32'd0, 32'd0);
    push_request(REQ_DEQ, 32'd0, 32'd0);

    for (int i = 0; i < 320; i++) begin
      idle_on = !(i >= 120 && i < 200);
      // alternate between growing and draining the queue
      filling = ((i / 40) % 2) == 0;
      pick = $urandom_range(99);
      if (filling)
        kind = pick < 55 ? REQ_ENQ : pick < 72 ? REQ_DEQ : pick < 86 ? REQ_QRY : REQ_DSP;
      else
        kind = pick < 20 ? REQ_ENQ : pick < 70 ? REQ_DEQ : pick < 82 ? REQ_QRY : REQ_DSP;
      // mostly a small key pool so duplicates show up
      if ($urandom_range(3) == 0) key = $urandom;
      else key = 32'($urandom_range(40)) - 32'd20;
      push_request(kind, key, $urandom);
    end
    req_ch.valid = 1'b0;
    idle_on      = 1'b1;

    while (shadow.owed.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (shadow.bad_results == 0 && shadow.owed.size() == 0) begin
      $display("** fifo_queue_unique_keys: PASSED **");
    end else begin
      $display("** fifo_queue_unique_keys: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/fqu_pkg.sv
rtl/fqu_chan_if.sv
rtl/fqu_store.sv
rtl/fifo_queue_unique_keys.sv
dv/fqu_queue_shadow_pkg.sv
dv/fifo_queue_unique_keys_test.sv
